// ===== sv/abam_pkg.sv =====
// ----------------------------------------------------------------------------
// abam_pkg
// Shared types and constants of the aligned bump allocator with address map.
// ----------------------------------------------------------------------------
`default_nettype none

package abam_pkg;

  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned SIZE_W            = 25;
  localparam int unsigned ALIGN_BYTES       = 32;
  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned CMD_DEPTH         = 2;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = 32;
  localparam logic [SIZE_W-1:0] HEAP_SIZE_RST = SIZE_W'(1048576);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_DONE
  } back_state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] heap_base;
    logic [SIZE_W-1:0] heap_size;
  } cfg_t;

  // classified command between front and back
  typedef struct packed {
    op_e               op;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] orig;
    logic [ADDR_W-1:0] conv;
    logic              pair_ok;   // both addresses nonzero
    logic              key_zero;  // lookup key is zero, always a miss
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              success;
    logic              overflow;
    logic [SIZE_W-1:0] high_water;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/aligned_bump_allocator_with_map_top.sv =====
// ----------------------------------------------------------------------------
// aligned_bump_allocator_with_map_top
// Bump allocator with 32-byte aligned block ends plus an address map table.
// ----------------------------------------------------------------------------
// path: front register, command queue, back state machine, output register;
//   clear and insert finish in S_IDLE, alloc passes through S_ALLOC,
//   lookup walks the table in S_SCAN to a hit or past the last entry,
//   key zero or an empty table finishes a lookup in S_IDLE
// throughput: one item at a time in the back, one table read per cycle
// reset: pointer, high-water mark, overflow and entry count go to zero,
//   heap_base 0, heap_size 1 MiB; table contents undefined until written
`default_nettype none

module aligned_bump_allocator_with_map_top #(
  parameter int unsigned TABLE_ENTRIES = abam_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // config write port
  input  wire logic                           cfg_we_i,
  input  wire logic [abam_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [abam_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // request side
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire logic [1:0]                     operation_i,
  input  wire logic [abam_pkg::SIZE_W-1:0]    request_size_i,
  input  wire logic [abam_pkg::ADDR_W-1:0]    original_addr_i,
  input  wire logic [abam_pkg::ADDR_W-1:0]    converted_addr_i,
  // result side
  output logic                                empty_o,
  input  wire logic                           pop_i,
  output logic [abam_pkg::ADDR_W-1:0]         result_addr_o,
  output logic                                success_o,
  output logic                                overflow_o,
  output logic [abam_pkg::SIZE_W-1:0]         high_water_o
);
  import abam_pkg::*;

  cfg_t cfg_q;
  cmd_t front_cmd;
  cmd_t queue_cmd;
  res_t res;
  logic front_push;
  logic queue_full;
  logic queue_empty;
  logic queue_pop;

  // config registers; a clear transfer must follow any write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heap_base <= '0;
      cfg_q.heap_size <= HEAP_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEAP_BASE: cfg_q.heap_base <= cfg_wdata_i[ADDR_W-1:0];
        REG_HEAP_SIZE: cfg_q.heap_size <= cfg_wdata_i[SIZE_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // front: register the item and classify it
  abam_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push_i),
    .full_o           (full_o),
    .operation_i      (operation_i),
    .request_size_i   (request_size_i),
    .original_addr_i  (original_addr_i),
    .converted_addr_i (converted_addr_i),
    .cmd_push_o       (front_push),
    .cmd_o            (front_cmd),
    .cmd_full_i       (queue_full)
  );

  // short queue so the front keeps taking items while the back works
  abam_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .data_o  (queue_cmd),
    .empty_o (queue_empty)
  );

  // back: allocator, table walk and output register
  abam_back #(
    .TableEntries (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (queue_cmd),
    .cmd_empty_i (queue_empty),
    .cmd_pop_o   (queue_pop),
    .res_o       (res),
    .res_empty_o (empty_o),
    .res_pop_i   (pop_i)
  );

  assign result_addr_o = res.addr;
  assign success_o     = res.success;
  assign overflow_o    = res.overflow;
  assign high_water_o  = res.high_water;

endmodule

`default_nettype wire

// ===== sv/abam_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// abam_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module abam_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  abam_pkg::cmd_t     data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output abam_pkg::cmd_t     data_o,
  output logic               empty_o
);
  import abam_pkg::*;

  localparam int unsigned PtrW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(CMD_DEPTH + 1);

  cmd_t            mem_q [CMD_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/abam_front.sv =====
// ----------------------------------------------------------------------------
// abam_front
// Input stage: takes items, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module abam_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  output logic                           full_o,
  input  wire logic [1:0]                operation_i,
  input  wire logic [abam_pkg::SIZE_W-1:0] request_size_i,
  input  wire logic [abam_pkg::ADDR_W-1:0] original_addr_i,
  input  wire logic [abam_pkg::ADDR_W-1:0] converted_addr_i,
  output logic                           cmd_push_o,
  output abam_pkg::cmd_t                 cmd_o,
  input  wire logic                      cmd_full_i
);
  import abam_pkg::*;

  logic valid_q, valid_d;
  cmd_t item_q;
  logic accept;

  assign cmd_push_o = valid_q && !cmd_full_i;
  assign full_o     = valid_q && cmd_full_i;
  assign accept     = push_i && !full_o;
  assign cmd_o      = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (cmd_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op       <= op_e'(operation_i);
      item_q.size     <= request_size_i;
      item_q.orig     <= original_addr_i;
      item_q.conv     <= converted_addr_i;
      item_q.pair_ok  <= (original_addr_i != '0) && (converted_addr_i != '0);
      item_q.key_zero <= (original_addr_i == '0);
    end
  end

endmodule

`default_nettype wire

// ===== sv/abam_back.sv =====
// ----------------------------------------------------------------------------
// abam_back
// Execution stage: allocator state, map table and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module abam_back #(
  parameter int unsigned TableEntries = abam_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  abam_pkg::cfg_t     cfg_i,
  input  abam_pkg::cmd_t     cmd_i,
  input  wire logic          cmd_empty_i,
  output logic               cmd_pop_o,
  output abam_pkg::res_t     res_o,
  output logic               res_empty_o,
  input  wire logic          res_pop_i
);
  import abam_pkg::*;

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned EndW = ADDR_W + 1;
  localparam logic [EndW-1:0] AlignMask = EndW'(ALIGN_BYTES - 1);
  localparam logic [SIZE_W-1:0] PeakMax = '1;

  back_state_e state_q, state_d;

  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [SIZE_W-1:0] peak_q, peak_d;
  logic              ovf_q, ovf_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   scan_q, scan_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [EndW-1:0]   end_q, end_d;
  logic [EndW-1:0]   limit_q, limit_d;
  logic [ADDR_W-1:0] key_q, key_d;
  res_t              res_q, res_d;
  res_t              out_q;
  logic              out_vld_q;
  logic              out_load;

  logic              finish;
  logic [ADDR_W-1:0] fin_addr;
  logic              fin_ok;
  logic [EndW-1:0]   offset;
  logic              mem_we;
  logic              rd_en;

  logic [ADDR_W-1:0] orig_mem [TableEntries];
  logic [ADDR_W-1:0] conv_mem [TableEntries];
  logic [ADDR_W-1:0] rd_orig_q, rd_conv_q;

  assign cmd_pop_o   = (state_q == S_IDLE) && !cmd_empty_i;
  assign res_o       = out_q;
  assign res_empty_o = !out_vld_q;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    peak_d    = peak_q;
    ovf_d     = ovf_q;
    cnt_d     = cnt_q;
    scan_d    = scan_q;
    cmp_vld_d = 1'b0;
    end_d     = end_q;
    limit_d   = limit_q;
    key_d     = key_q;
    res_d     = res_q;
    finish    = 1'b0;
    fin_addr  = '0;
    fin_ok    = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    offset    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.op)
            OP_ALLOC: begin
              end_d   = ({1'b0, ptr_q} + EndW'(cmd_i.size) + AlignMask) & ~AlignMask;
              limit_d = {1'b0, cfg_i.heap_base} + EndW'(cfg_i.heap_size);
              state_d = S_ALLOC;
            end
            OP_INSERT: begin
              finish = 1'b1;
              if ((cnt_q < CntW'(TableEntries)) && cmd_i.pair_ok) begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CntW'(1);
                fin_ok = 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_LOOKUP: begin
              if (cmd_i.key_zero || (cnt_q == '0)) begin
                finish = 1'b1;
              end else begin
                key_d   = cmd_i.orig;
                scan_d  = '0;
                state_d = S_SCAN;
              end
            end
            OP_CLEAR: begin
              ptr_d  = cfg_i.heap_base;
              ovf_d  = 1'b0;
              cnt_d  = '0;
              fin_ok = 1'b1;
              finish = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_ALLOC: begin
        finish = 1'b1;
        offset = (end_q >= {1'b0, cfg_i.heap_base}) ? end_q - {1'b0, cfg_i.heap_base} : '0;
        // saturate offset into the high-water width
        if (offset[EndW-1:SIZE_W] != '0) begin
          if (PeakMax > peak_q) peak_d = PeakMax;
        end else if (offset[SIZE_W-1:0] > peak_q) begin
          peak_d = offset[SIZE_W-1:0];
        end
        if ((end_q > limit_q) || end_q[EndW-1]) begin
          ovf_d = 1'b1;
        end else begin
          ptr_d    = end_q[ADDR_W-1:0];
          fin_addr = ptr_q;
          fin_ok   = 1'b1;
        end
      end

      S_SCAN: begin
        // one table read issued per cycle, compared in the cycle after
        if (cmp_vld_q && (rd_orig_q == key_q)) begin
          finish   = 1'b1;
          fin_addr = rd_conv_q;
          fin_ok   = 1'b1;
        end else if (scan_q < cnt_q) begin
          rd_en     = 1'b1;
          scan_d    = scan_q + CntW'(1);
          cmp_vld_d = 1'b1;
        end else if (!cmp_vld_q) begin
          finish = 1'b1;
        end
      end

      S_DONE: begin
        if (!out_vld_q || res_pop_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (finish) begin
      res_d.addr       = fin_addr;
      res_d.success    = fin_ok;
      res_d.overflow   = ovf_d;
      res_d.high_water = peak_d;
      state_d          = S_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ptr_q     <= '0;
      peak_q    <= '0;
      ovf_q     <= 1'b0;
      cnt_q     <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      peak_q    <= peak_d;
      ovf_q     <= ovf_d;
      cnt_q     <= cnt_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    end_q   <= end_d;
    limit_q <= limit_d;
    key_q   <= key_d;
    res_q   <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // map table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      orig_mem[cnt_q[IdxW-1:0]] <= cmd_i.orig;
      conv_mem[cnt_q[IdxW-1:0]] <= cmd_i.conv;
    end
    if (rd_en) begin
      rd_orig_q <= orig_mem[scan_q[IdxW-1:0]];
      rd_conv_q <= conv_mem[scan_q[IdxW-1:0]];
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TableEntries))
    else $error("entry count past table depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_q <= cnt_q))
    else $error("scan index past entry count");

  a_clear_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && (cmd_i.op == OP_CLEAR)) |=>
      ((ptr_q == $past(cfg_i.heap_base)) && (cnt_q == '0) && !ovf_q))
    else $error("clear did not rewind allocator and table");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && out_vld_q && !res_pop_i) |=> (state_q == S_DONE))
    else $error("result dropped while output register busy");

endmodule

`default_nettype wire
